// File: src/fwsm_pkg.sv
package fwsm_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned PatMax  = 10;
  localparam int unsigned LenW    = 4;
  localparam int unsigned HeadW   = 64;
  localparam int unsigned TailW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PATTERN_HEAD   = 2'd0,
    REG_PATTERN_TAIL   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_IGNORE_CASE    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic            shift_en;
    logic            ignore_case;
    logic [LenW-1:0] pat_len;
  } cell_ctrl_t;

  function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c, input logic ic);
    logic [CharW-1:0] r;
    r = c;
    if (ic && c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  function automatic logic [CharW-1:0] pat_byte(input logic [HeadW-1:0] head,
                                                input logic [TailW-1:0] tail,
                                                input logic [LenW-1:0]  idx);
    logic [CharW-1:0] r;
    if (idx < 4'd8) begin
      r = head[8*idx[2:0] +: 8];
    end else begin
      r = tail[8*idx[0] +: 8];
    end
    return r;
  endfunction

endpackage

// File: src/fwsm_cell.sv
module fwsm_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                                clk,
  input  fwsm_pkg::cell_ctrl_t                ctrl,
  input  logic [fwsm_pkg::HeadW-1:0]          pat_head,
  input  logic [fwsm_pkg::TailW-1:0]          pat_tail,
  input  logic [fwsm_pkg::CharW-1:0]          byte_in,
  output logic [fwsm_pkg::CharW-1:0]          byte_out,
  output logic                                ok
);

  localparam logic [fwsm_pkg::LenW-1:0] PosC = fwsm_pkg::LenW'(POS);

  logic [fwsm_pkg::CharW-1:0] byte_r;
  logic [fwsm_pkg::LenW-1:0]  idx;
  logic [fwsm_pkg::CharW-1:0] want;

  always_comb begin
    idx  = ctrl.pat_len - PosC - 4'd1;
    want = fwsm_pkg::pat_byte(pat_head, pat_tail, idx);
    if (PosC >= ctrl.pat_len) begin
      ok = 1'b1;
    end else begin
      ok = fwsm_pkg::fold(byte_in, ctrl.ignore_case) ==
           fwsm_pkg::fold(want, ctrl.ignore_case);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift_en) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

// File: src/fixed_window_substring_match_core.sv
// Reports whether the configured pattern (1 to 10 bytes) occurs in a text window
// that streams in one byte per transfer, with the final byte marked by in_tlast.
// One byte is taken every clock cycle while in_tready is high; the found flag for
// a window is presented on the output in the cycle after its last byte is taken and
// holds until taken. While a result waits and out_tready is low, in_tready is held
// low as well. A row of WINDOW cells holds the recent bytes and compares all
// pattern positions in the same cycle, so the rate is one byte per cycle at any
// pattern length. Bytes past the first WINDOW of a window are ignored. The user is
// to write configuration via cfg_we/cfg_addr/cfg_wdata only while idle; unchecked.
module fixed_window_substring_match_core #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fwsm_pkg::CfgIdxW-1:0]     cfg_addr,
  input  logic [fwsm_pkg::CfgDatW-1:0]     cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,  // text_char [7:0]
  input  logic                             in_tlast,  // last_char
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata  // found [0], zero [7:1]
);

  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam logic [CntW-1:0] WinC = CntW'(WINDOW);

  logic [fwsm_pkg::HeadW-1:0] pat_head_r;
  logic [fwsm_pkg::TailW-1:0] pat_tail_r;
  logic [fwsm_pkg::LenW-1:0]  pat_len_r;
  logic                       ignore_case_r;

  logic [CntW-1:0] chars_seen_r, chars_seen_nxt;
  logic            hit_r, hit_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            found_r, found_nxt;

  logic                 accept;
  logic                 in_range;
  logic                 match;
  logic [4:0]           seen_p1;
  fwsm_pkg::cell_ctrl_t ctrl;

  logic [fwsm_pkg::CharW-1:0] chain [WINDOW+1];
  logic [WINDOW-1:0]          cell_ok;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign in_range  = chars_seen_r < WinC;

  assign ctrl.shift_en    = accept && in_range;
  assign ctrl.ignore_case = ignore_case_r;
  assign ctrl.pat_len     = pat_len_r;

  assign chain[0] = in_tdata;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    fwsm_cell #(.POS(k)) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .pat_head (pat_head_r),
      .pat_tail (pat_tail_r),
      .byte_in  (chain[k]),
      .byte_out (chain[k+1]),
      .ok       (cell_ok[k])
    );
  end

  always_comb begin
    seen_p1 = 5'(chars_seen_r) + 5'd1;
    match   = (pat_len_r != '0) && (5'(pat_len_r) <= 5'(WINDOW)) &&
              (seen_p1 >= 5'(pat_len_r)) && (&cell_ok);

    chars_seen_nxt = chars_seen_r;
    hit_nxt        = hit_r;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    if (accept) begin
      if (in_range) begin
        hit_nxt        = hit_r || match;
        chars_seen_nxt = chars_seen_r + 1'b1;
      end
      if (in_tlast) begin
        found_nxt      = hit_nxt;
        out_valid_nxt  = 1'b1;
        chars_seen_nxt = '0;
        hit_nxt        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_seen_r  <= '0;
      hit_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      pat_head_r    <= '0;
      pat_tail_r    <= '0;
      pat_len_r     <= '0;
      ignore_case_r <= 1'b0;
    end else begin
      chars_seen_r <= chars_seen_nxt;
      hit_r        <= hit_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (fwsm_pkg::cfg_reg_t'(cfg_addr))
          fwsm_pkg::REG_PATTERN_HEAD:   pat_head_r    <= cfg_wdata;
          fwsm_pkg::REG_PATTERN_TAIL:   pat_tail_r    <= cfg_wdata[fwsm_pkg::TailW-1:0];
          fwsm_pkg::REG_PATTERN_LENGTH: pat_len_r     <= cfg_wdata[fwsm_pkg::LenW-1:0];
          fwsm_pkg::REG_IGNORE_CASE:    ignore_case_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, found_r};

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    chars_seen_r <= WinC)
    else $error("byte count exceeds window");

  a_count_step : assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_tlast && in_range |=> chars_seen_r == $past(chars_seen_r) + 1'b1)
    else $error("byte count did not advance");

  a_window_end : assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> chars_seen_r == '0 && !hit_r && out_valid_r)
    else $error("window end did not clear state or post a result");

  a_zero_len : assert property (@(posedge clk) disable iff (!rst_n)
    accept && pat_len_r == '0 && !hit_r |=> !hit_r)
    else $error("hit with zero pattern length");

endmodule
